// File: design/brute_force_top_k_nearest_macros.svh
// Assertion macros used by the checker of the nearest-neighbor search block.
// No dependencies; include by bare file name.
`ifndef BRUTE_FORCE_TOP_K_NEAREST_MACROS_SVH
`define BRUTE_FORCE_TOP_K_NEAREST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFKNN_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFKNN_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bfknn_pkg.sv
// Shared types, widths and codes for the brute-force nearest-neighbor search block.
// No dependencies; imported by the front, queue, back and top modules.
package bfknn_pkg;

    // Defaults for the top-level parameters
    localparam int TOP_COUNT_DEF  = 8;
    localparam int DIM_MAX_DEF    = 256;
    localparam int MAX_POINTS_DEF = 1048576;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Field widths
    localparam int OP_W       = 2;
    localparam int COORD_W    = 16;
    localparam int DIMS_W     = 9;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W + 1;
    localparam int DIST_W     = 40;
    localparam int INDEX_W    = 20;
    localparam int RANK_W     = 3;
    localparam int OUT_DATA_W = 64;

    localparam logic [DIMS_W-1:0] DIMS_RESET = 9'd256;
    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};

    // Input operation codes
    localparam logic [OP_W-1:0] OP_LOAD_QUERY = 2'd0;
    localparam logic [OP_W-1:0] OP_POINT      = 2'd1;
    localparam logic [OP_W-1:0] OP_EMIT       = 2'd2;

    // Work handed from front to back
    typedef struct packed {
        logic               emit;       // flush the top list
        logic [DIFF_W-1:0]  diff;       // coordinate minus query, two's complement
        logic               point_end;  // last coordinate of a point
        logic               insert;     // point counts (below the point limit)
        logic [INDEX_W-1:0] index;      // stream index of the point
    } bfknn_cmd_t;

endpackage

// File: design/bfknn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfknn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/bfknn_front.sv
// Front end: accepts input transfers, keeps the query RAM, coordinate positions and
// point count, and turns each data coordinate into a difference command. Uses bfknn_pkg, bfknn_ram.
module bfknn_front #(
    parameter int DIM_MAX    = bfknn_pkg::DIM_MAX_DEF,
    parameter int MAX_POINTS = bfknn_pkg::MAX_POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bfknn_pkg::COORD_W-1:0]     s_axis_tdata,
    input  logic [bfknn_pkg::OP_W-1:0]        s_axis_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfknn_pkg::DIMS_W-1:0]      cfg_data,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output bfknn_pkg::bfknn_cmd_t             cmd
);
    import bfknn_pkg::*;

    localparam int AW   = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int DW   = $clog2(DIM_MAX + 1);
    localparam int CMPW = ((DW > DIMS_W) ? DW : DIMS_W) + 1;
    localparam int PCW  = $clog2(MAX_POINTS + 1);

    logic [DIMS_W-1:0]  dims_reg;
    logic [AW-1:0]      qpos_reg, qpos_next;
    logic [AW-1:0]      cpos_reg, cpos_next;
    logic [PCW-1:0]     pcnt_reg, pcnt_next;
    logic               s1_valid_reg;
    logic               s1_emit_reg;
    logic [COORD_W-1:0] s1_coord_reg;
    logic               s1_end_reg;
    logic               s1_ins_reg;
    logic [INDEX_W-1:0] s1_index_reg;

    logic [DIMS_W-1:0]  dims_nz;
    logic [CMPW-1:0]    dims_eff;
    logic [AW-1:0]      qpos_eff, cpos_eff;
    logic [CMPW-1:0]    qpos_inc, cpos_inc;
    logic               q_wrap, c_wrap;
    logic               pnt_room;
    logic               accept;
    logic               is_load, is_point, is_emit;
    logic [COORD_W-1:0] q_rd_data;

    // Effective dimension: zero acts as one, clipped to the RAM depth
    assign dims_nz  = (dims_reg == '0) ? DIMS_W'(1) : dims_reg;
    assign dims_eff = (CMPW'(dims_nz) > CMPW'(DIM_MAX)) ? CMPW'(DIM_MAX) : CMPW'(dims_nz);

    // Restart stale positions, then step with wrap
    assign qpos_eff = (CMPW'(qpos_reg) >= dims_eff) ? '0 : qpos_reg;
    assign cpos_eff = (CMPW'(cpos_reg) >= dims_eff) ? '0 : cpos_reg;
    assign qpos_inc = CMPW'(qpos_eff) + CMPW'(1);
    assign cpos_inc = CMPW'(cpos_eff) + CMPW'(1);
    assign q_wrap   = (qpos_inc >= dims_eff);
    assign c_wrap   = (cpos_inc >= dims_eff);
    assign pnt_room = (pcnt_reg < PCW'(MAX_POINTS));

    // Handshakes
    assign s_axis_tready = !s1_valid_reg || cmd_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Classify the operation
    always_comb
    begin
        is_load  = 1'b0;
        is_point = 1'b0;
        is_emit  = 1'b0;
        unique case (s_axis_tuser)
            OP_LOAD_QUERY: is_load  = 1'b1;
            OP_POINT:      is_point = 1'b1;
            OP_EMIT:       is_emit  = 1'b1;
            default:       ;
        endcase
    end

    // Query store: write on load, read the matching coordinate on a data point
    bfknn_ram #(
        .WIDTH (COORD_W),
        .DEPTH (DIM_MAX),
        .AW    (AW)
    ) u_query_ram (
        .clk     (clk),
        .wr_en   (accept && is_load),
        .wr_addr (qpos_eff),
        .wr_data (s_axis_tdata),
        .rd_en   (accept && is_point),
        .rd_addr (cpos_eff),
        .rd_data (q_rd_data)
    );

    // Next positions and point count
    always_comb
    begin
        qpos_next = qpos_reg;
        cpos_next = cpos_reg;
        pcnt_next = pcnt_reg;
        if (accept && is_load)
        begin
            qpos_next = q_wrap ? '0 : qpos_inc[AW-1:0];
        end
        if (accept && is_point)
        begin
            cpos_next = c_wrap ? '0 : cpos_inc[AW-1:0];
            if (c_wrap && pnt_room)
            begin
                pcnt_next = pcnt_reg + PCW'(1);
            end
        end
        if (accept && is_emit)
        begin
            cpos_next = '0;
            pcnt_next = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg     <= DIMS_RESET;
            qpos_reg     <= '0;
            cpos_reg     <= '0;
            pcnt_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                dims_reg <= cfg_data;
            end
            qpos_reg <= qpos_next;
            cpos_reg <= cpos_next;
            pcnt_reg <= pcnt_next;
            if (accept)
            begin
                s1_valid_reg <= is_point || is_emit;
            end
            else if (cmd_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Command payload, waits here for the RAM read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg  <= is_emit;
            s1_coord_reg <= s_axis_tdata;
            s1_end_reg   <= c_wrap;
            s1_ins_reg   <= c_wrap && pnt_room;
            s1_index_reg <= INDEX_W'(pcnt_reg);
        end
    end

    // Form the command toward the queue
    assign cmd_valid     = s1_valid_reg;
    assign cmd.emit      = s1_emit_reg;
    assign cmd.diff      = {s1_coord_reg[COORD_W-1], s1_coord_reg}
                         - {q_rd_data[COORD_W-1], q_rd_data};
    assign cmd.point_end = s1_end_reg;
    assign cmd.insert    = s1_ins_reg;
    assign cmd.index     = s1_index_reg;

endmodule

// File: design/bfknn_fifo.sv
// Short command queue between front and back, registers only.
// Uses bfknn_pkg for the command type.
module bfknn_fifo #(
    parameter int DEPTH = bfknn_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  bfknn_pkg::bfknn_cmd_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output bfknn_pkg::bfknn_cmd_t pop_data
);
    import bfknn_pkg::*;

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    bfknn_cmd_t      entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CNTW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNTW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNTW'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/bfknn_back.sv
// Back end: squares differences, accumulates the distance, inserts finished points into
// the sorted top list and shifts the list out on emit. Uses bfknn_pkg.
module bfknn_back #(
    parameter int TOP_COUNT = bfknn_pkg::TOP_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  bfknn_pkg::bfknn_cmd_t               cmd,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bfknn_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);
    import bfknn_pkg::*;

    localparam int CW = ($clog2(TOP_COUNT) > RANK_W) ? $clog2(TOP_COUNT) : RANK_W;

    // Pipeline stage A: squared difference
    logic               a_valid_reg, a_emit_reg, a_end_reg, a_ins_reg;
    logic [INDEX_W-1:0] a_index_reg;
    logic [SQ_W-1:0]    a_sq_reg;
    // Stage B: accumulator
    logic [DIST_W-1:0]  acc_reg;
    // Stage C: finished point or emit request
    logic               c_valid_reg, c_emit_reg;
    logic [DIST_W-1:0]  c_dist_reg;
    logic [INDEX_W-1:0] c_index_reg;
    // Top list
    logic [DIST_W-1:0]  dist_reg   [TOP_COUNT];
    logic [INDEX_W-1:0] index_reg  [TOP_COUNT];
    logic [TOP_COUNT-1:0] filled_reg;
    logic [DIST_W-1:0]  dist_next  [TOP_COUNT];
    logic [INDEX_W-1:0] index_next [TOP_COUNT];
    logic [TOP_COUNT-1:0] filled_next;
    // Emit sequencer and output register
    logic               emit_busy_reg;
    logic [CW-1:0]      cnt_reg;
    logic               m_valid_reg, m_filled_reg, m_last_reg;
    logic [RANK_W-1:0]  m_rank_reg;
    logic [INDEX_W-1:0] m_index_reg;
    logic [DIST_W-1:0]  m_dist_reg;

    logic                  adv, pop, emit_go, emit_done, do_insert;
    logic signed [2*DIFF_W-1:0] prod;
    logic [DIST_W:0]       sum;
    logic [DIST_W-1:0]     sat;
    logic [TOP_COUNT-1:0]  lt;

    // Pipeline advances unless the list is being shifted out
    assign adv       = !emit_busy_reg;
    assign cmd_ready = adv;
    assign pop       = cmd_valid && adv;
    assign emit_go   = emit_busy_reg && (!m_valid_reg || m_axis_tready);
    assign emit_done = emit_go && (cnt_reg == CW'(TOP_COUNT - 1));
    assign do_insert = adv && c_valid_reg && !c_emit_reg;

    // Square the difference
    assign prod = $signed(cmd.diff) * $signed(cmd.diff);

    // Saturating accumulate
    assign sum = {1'b0, acc_reg} + (DIST_W + 1)'(a_sq_reg);
    assign sat = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

    // Insertion slot compare, one per slot
    always_comb
    begin
        for (int i = 0; i < TOP_COUNT; i++)
        begin
            lt[i] = !filled_reg[i] || (c_dist_reg < dist_reg[i]);
        end
    end

    // Next list: shift out on emit, compare-shift insert otherwise
    always_comb
    begin
        logic               prev_lt;
        logic [DIST_W-1:0]  carry_dist;
        logic [INDEX_W-1:0] carry_index;
        logic               carry_filled;
        prev_lt      = 1'b0;
        carry_dist   = '0;
        carry_index  = '0;
        carry_filled = 1'b0;
        for (int i = 0; i < TOP_COUNT; i++)
        begin
            dist_next[i]   = dist_reg[i];
            index_next[i]  = index_reg[i];
            filled_next[i] = filled_reg[i];
        end
        if (emit_go)
        begin
            for (int i = TOP_COUNT - 1; i >= 0; i--)
            begin
                dist_next[i]   = carry_dist;
                index_next[i]  = carry_index;
                filled_next[i] = carry_filled;
                carry_dist     = dist_reg[i];
                carry_index    = index_reg[i];
                carry_filled   = filled_reg[i];
            end
        end
        else if (do_insert)
        begin
            for (int i = 0; i < TOP_COUNT; i++)
            begin
                if (lt[i] && !prev_lt)
                begin
                    dist_next[i]   = c_dist_reg;
                    index_next[i]  = c_index_reg;
                    filled_next[i] = 1'b1;
                end
                else if (lt[i])
                begin
                    dist_next[i]   = carry_dist;
                    index_next[i]  = carry_index;
                    filled_next[i] = carry_filled;
                end
                prev_lt      = lt[i];
                carry_dist   = dist_reg[i];
                carry_index  = index_reg[i];
                carry_filled = filled_reg[i];
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            acc_reg       <= '0;
            filled_reg    <= '0;
            emit_busy_reg <= 1'b0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            filled_reg <= filled_next;
            if (adv)
            begin
                a_valid_reg <= pop;
                c_valid_reg <= a_valid_reg && (a_emit_reg || (a_end_reg && a_ins_reg));
                if (a_valid_reg)
                begin
                    acc_reg <= (a_emit_reg || a_end_reg) ? '0 : sat;
                end
                if (c_valid_reg && c_emit_reg)
                begin
                    emit_busy_reg <= 1'b1;
                    cnt_reg       <= '0;
                end
            end
            if (emit_go)
            begin
                cnt_reg     <= cnt_reg + CW'(1);
                m_valid_reg <= 1'b1;
                if (emit_done)
                begin
                    emit_busy_reg <= 1'b0;
                end
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TOP_COUNT; i++)
        begin
            dist_reg[i]  <= dist_next[i];
            index_reg[i] <= index_next[i];
        end
        if (pop)
        begin
            a_emit_reg  <= cmd.emit;
            a_end_reg   <= cmd.point_end;
            a_ins_reg   <= cmd.insert;
            a_index_reg <= cmd.index;
            a_sq_reg    <= prod[SQ_W-1:0];
        end
        if (adv && a_valid_reg)
        begin
            c_emit_reg  <= a_emit_reg;
            c_dist_reg  <= sat;
            c_index_reg <= a_index_reg;
        end
        if (emit_go)
        begin
            m_rank_reg   <= cnt_reg[RANK_W-1:0];
            m_index_reg  <= filled_reg[0] ? index_reg[0] : '0;
            m_dist_reg   <= filled_reg[0] ? dist_reg[0] : '0;
            m_filled_reg <= filled_reg[0];
            m_last_reg   <= (cnt_reg == CW'(TOP_COUNT - 1));
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_dist_reg, m_index_reg, m_rank_reg};
    assign m_axis_tuser  = m_filled_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

// File: design/brute_force_top_k_nearest.sv
// Channel  | Valid/ready                    | Payload
// ---------+--------------------------------+---------------------------------------------
// in       | s_axis_tvalid / s_axis_tready  | tdata: coord[15:0]; tuser: op[1:0]
// out      | m_axis_tvalid / m_axis_tready  | tdata: rank, point_index, sq_distance; tuser: filled; tlast
// config   | cfg_valid / cfg_ready          | cfg_data: dims_in_use[8:0]
//
// Query loads and data coordinates wait for s_axis_tready; the front is limited by the single
// query RAM port and the back by one multiply-accumulate per coordinate behind a 4-deep queue.
// An emit shifts the top list out entry by entry; the back takes no new work meanwhile.
// A finished point enters the list after the front register, the queue and back stages A and C.
// Reset is asynchronous; no clearing pass. The query RAM holds garbage until loaded.
// Uses bfknn_pkg, bfknn_front, bfknn_fifo, bfknn_back.
module brute_force_top_k_nearest #(
    parameter int TOP_COUNT  = bfknn_pkg::TOP_COUNT_DEF,
    parameter int DIM_MAX    = bfknn_pkg::DIM_MAX_DEF,
    parameter int MAX_POINTS = bfknn_pkg::MAX_POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bfknn_pkg::COORD_W-1:0]     s_axis_tdata,   // [15:0] coord
    input  logic [bfknn_pkg::OP_W-1:0]        s_axis_tuser,   // [1:0] op
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bfknn_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [2:0] rank, [22:3] point_index,
                                                              // [62:23] sq_distance, [63] zero
    output logic                              m_axis_tuser,   // [0] filled
    output logic                              m_axis_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfknn_pkg::DIMS_W-1:0]      cfg_data
);
    import bfknn_pkg::*;

    bfknn_cmd_t front_cmd, back_cmd;
    logic       front_valid, front_ready;
    logic       back_valid, back_ready;

    // Accept and classify
    bfknn_front #(
        .DIM_MAX    (DIM_MAX),
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .cmd_valid     (front_valid),
        .cmd_ready     (front_ready),
        .cmd           (front_cmd)
    );

    // Decouple front from back
    bfknn_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cmd)
    );

    // Distance, ranking and emit
    bfknn_back #(
        .TOP_COUNT (TOP_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (back_valid),
        .cmd_ready     (back_ready),
        .cmd           (back_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: design/bfknn_checker.sv
// Port-level checks for the nearest-neighbor search block, bound to the top level.
// Uses bfknn_pkg and brute_force_top_k_nearest_macros.svh.
`include "brute_force_top_k_nearest_macros.svh"

module bfknn_checker #(
    parameter int TOP_COUNT = bfknn_pkg::TOP_COUNT_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [bfknn_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tuser,
    input logic                              m_axis_tlast
);
    import bfknn_pkg::*;

    // Stalled result holds
    `BFKNN_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // Final result carries the last rank
    `BFKNN_ASSERT_SAME(a_last_rank, clk, rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[RANK_W-1:0] == RANK_W'(TOP_COUNT - 1), "last result has wrong rank")

    // Empty slot shows zero index and distance
    `BFKNN_ASSERT_SAME(a_empty_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[OUT_DATA_W-1:RANK_W] == '0, "empty slot carries data")

    // Empty slots trail the filled ones
    `BFKNN_ASSERT_NEXT(a_empty_trail, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tuser && !m_axis_tlast, !m_axis_tvalid || !m_axis_tuser, "filled slot after empty slot")

endmodule

bind brute_force_top_k_nearest bfknn_checker #(.TOP_COUNT(TOP_COUNT)) u_bfknn_checker (.*);
